FILE: sv/ck32_pkg.sv
// ----------------------------------------------------------------------------
// ck32_pkg
// Shared types, constants and the byte-wide CRC-32 step for the checksum
// engine.
// ----------------------------------------------------------------------------
package ck32_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_MSB  = 32'h8000_0000;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,   // taking message words
    ST_TAIL = 2'b10    // folding length bytes, then emitting
  } ck32_state_t;

  // Controller to datapath
  typedef struct packed {
    logic feed_byte;   // accepted word carries a message byte
    logic start_tail;  // accepted word closes the message
    logic feed_tail;   // fold low length byte into the CRC
    logic emit;        // load result register, clear running state
  } ck32_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rem_zero;    // no length bytes left to fold
  } ck32_status_t;

  // One byte through the non-reflected CRC-32, MSB first
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = ((c & CRC_MSB) != 32'h0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/ck32_in_if.sv
// ----------------------------------------------------------------------------
// ck32_in_if
// Message word channel: one optional byte plus an end-of-message mark.
// ----------------------------------------------------------------------------
interface ck32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

FILE: sv/ck32_out_if.sv
// ----------------------------------------------------------------------------
// ck32_out_if
// Result channel: inverted CRC and byte count of one message.
// ----------------------------------------------------------------------------
interface ck32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;
  logic [31:0] byte_count;

  modport source (output valid, output checksum, output byte_count, input ready);
  modport sink   (input valid, input checksum, input byte_count, output ready);
endinterface

FILE: sv/ck32_ctrl.sv
// ----------------------------------------------------------------------------
// ck32_ctrl
// Sequencer: takes message words, walks the length tail, and owns the
// result register's valid flag.
// ----------------------------------------------------------------------------
module ck32_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_has_byte,
  input  logic                    in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ck32_pkg::ck32_cmd_t     cmd,
  input  ck32_pkg::ck32_status_t  status
);
  import ck32_pkg::*;

  ck32_state_t state, state_next;
  logic        out_valid_next;
  logic        in_fire;
  logic        slot_free;

  assign in_ready  = (state == ST_RUN);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Commands
  always_comb begin
    cmd.feed_byte  = in_fire && in_has_byte;
    cmd.start_tail = in_fire && in_last;
    cmd.feed_tail  = (state == ST_TAIL) && !status.rem_zero;
    cmd.emit       = (state == ST_TAIL) && status.rem_zero && slot_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (cmd.start_tail) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        if (cmd.emit) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Result valid: set on emit, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.emit)               out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Closing word always starts the tail walk
  a_last_to_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.start_tail |=> (state == ST_TAIL))
    else $error("closing word did not enter tail");

  // Finished tail waits while the result register is occupied
  a_hold_tail: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_TAIL) && status.rem_zero && out_valid && !out_ready) |=>
      (state == ST_TAIL))
    else $error("tail left with result register full");

  // Emit always presents a result next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emit without result valid");

  // A result only appears after an emit
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result valid without emit");

endmodule

FILE: sv/ck32_datapath.sv
// ----------------------------------------------------------------------------
// ck32_datapath
// Running CRC, byte counter, length shifter and result register.
// ----------------------------------------------------------------------------
module ck32_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              data_byte,
  input  ck32_pkg::ck32_cmd_t     cmd,
  output ck32_pkg::ck32_status_t  status,
  output logic [31:0]             checksum,
  output logic [31:0]             byte_count
);
  import ck32_pkg::*;

  logic [31:0] crc;
  logic [31:0] count;
  logic [31:0] rem;
  logic [31:0] count_next;
  logic [7:0]  crc_in;
  logic [31:0] crc_step;

  // One shared byte step: message byte or low length byte
  assign crc_in     = cmd.feed_tail ? rem[7:0] : data_byte;
  assign crc_step   = crc_feed(crc, crc_in);
  assign count_next = count + 32'd1;

  assign status.rem_zero = (rem == 32'h0);

  // Running state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= 32'h0;
      count <= 32'h0;
    end else if (cmd.emit) begin
      crc   <= 32'h0;
      count <= 32'h0;
    end else begin
      if (cmd.feed_byte || cmd.feed_tail) crc <= crc_step;
      if (cmd.feed_byte)                  count <= count_next;
    end
  end

  // Length shifter, loaded with the final count
  always_ff @(posedge clk) begin
    if (cmd.start_tail) begin
      rem <= cmd.feed_byte ? count_next : count;
    end else if (cmd.feed_tail) begin
      rem <= rem >> 8;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      checksum   <= ~crc;
      byte_count <= count;
    end
  end

endmodule

FILE: sv/cksum_crc32_engine.sv
// ----------------------------------------------------------------------------
// cksum_crc32_engine
// Streaming POSIX cksum: CRC-32 over message bytes, then the length bytes.
//
//   channel | dir | fields                       | word
//   msg     | in  | data_byte, has_byte, last    | one optional byte
//   res     | out | checksum, byte_count         | one result per message
//
// Message words are taken in RUN; the byte CRC step is combinational.
// A closing word starts a walk over the length bytes up to the highest nonzero one (0 to 4),
// one byte a cycle through the same CRC step, followed by an emit.
// Synchronous reset clears the CRC, the counter, the state and res.valid.
// The result sits in a register; a new message streams in while it waits,
// and only the next emit stalls, holding off msg words, until the previous result is taken.
// ----------------------------------------------------------------------------
module cksum_crc32_engine (
  input  logic        clk,
  input  logic        rst,
  ck32_in_if.sink     msg,
  ck32_out_if.source  res
);
  import ck32_pkg::*;

  ck32_cmd_t    cmd;
  ck32_status_t status;

  ck32_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (msg.valid),
    .in_has_byte (msg.has_byte),
    .in_last     (msg.last),
    .in_ready    (msg.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .cmd         (cmd),
    .status      (status)
  );

  ck32_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (msg.data_byte),
    .cmd        (cmd),
    .status     (status),
    .checksum   (res.checksum),
    .byte_count (res.byte_count)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cksum_crc32_engine. Message words come from a queue
// filled up front: first a short directed set, then random messages of mostly
// short lengths with a few long ones and some empty-word noise. A bit-serial
// CRC-32 model tracks each accepted word and queues the checksum and count
// expected when a message closes. Every result taken from the block is
// compared against the oldest queued one. Both channels idle at random, with
// one stretch of full throughput.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ck32_pkg::*;

  localparam int WORD_TARGET = 1650;   // message-bearing words to send
  localparam int IDLE_PCT    = 28;
  localparam int STALL_LIMIT = 5000;   // cycles without any handshake
  localparam int TAIL_CYCLES = 20;     // settle time after the last result

  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    bit         wait_drain;  // hold this word until all results are in
  } msg_word_t;

  typedef struct {
    logic [31:0] checksum;
    logic [31:0] byte_count;
  } cksum_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ck32_in_if  msg_if ();
  ck32_out_if res_if ();

  cksum_crc32_engine uut (
    .clk (clk),
    .rst (rst),
    .msg (msg_if),
    .res (res_if)
  );

  always #2 clk = ~clk;

  msg_word_t     pending_words[$];
  cksum_result_t checksums_due[$];

  // running model state
  logic [31:0] model_crc   = '0;
  logic [31:0] model_count = '0;

  int fail_count     = 0;
  int accepted_words = 0;
  int results_seen   = 0;
  int msgs_closed    = 0;
  int empty_msgs     = 0;
  int longest_msg    = 0;
  int queued_words   = 0;

  // full throughput on both sides while this is set
  wire steady = (accepted_words >= 700) && (accepted_words < 1000);

  // MSB-first CRC-32, one bit per iteration
  function automatic logic [31:0] crc_shift_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[31] ^ b[i];
      r  = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  // advance the model by one accepted word
  task automatic absorb_word(logic [7:0] data_byte, logic has_byte, logic last);
    logic [31:0]   rem;
    cksum_result_t sum;
    if (has_byte) begin
      model_crc   = crc_shift_byte(model_crc, data_byte);
      model_count = model_count + 32'd1;
    end
    if (last) begin
      // fold in the length, low byte first, until nothing is left
      rem = model_count;
      while (rem != 32'h0) begin
        model_crc = crc_shift_byte(model_crc, rem[7:0]);
        rem       = rem >> 8;
      end
      sum.checksum   = ~model_crc;
      sum.byte_count = model_count;
      checksums_due.push_back(sum);
      msgs_closed++;
      if (model_count == 0) empty_msgs++;
      if (int'(model_count) > longest_msg) longest_msg = int'(model_count);
      model_crc   = '0;
      model_count = '0;
    end
  endtask

  // driver: present queued words, model each accepted one
  always @(posedge clk) begin
    if (rst) begin
      msg_if.valid <= 1'b0;
    end else begin
      if (msg_if.valid && msg_if.ready) begin
        absorb_word(msg_if.data_byte, msg_if.has_byte, msg_if.last);
        accepted_words++;
      end
      if (!msg_if.valid || msg_if.ready) begin
        if (pending_words.size() > 0 &&
            !(pending_words[0].wait_drain && checksums_due.size() > 0) &&
            (steady || $urandom_range(99) >= IDLE_PCT)) begin
          msg_if.valid     <= 1'b1;
          msg_if.data_byte <= pending_words[0].data_byte;
          msg_if.has_byte  <= pending_words[0].has_byte;
          msg_if.last      <= pending_words[0].last;
          void'(pending_words.pop_front());
        end else begin
          msg_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: take results and compare with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (checksums_due.size() == 0) begin
          $error("unexpected result: checksum %08h byte_count %0d",
                 res_if.checksum, res_if.byte_count);
          fail_count++;
        end else begin
          if (res_if.checksum !== checksums_due[0].checksum) begin
            $error("checksum: expected %08h, actual %08h",
                   checksums_due[0].checksum, res_if.checksum);
            fail_count++;
          end
          if (res_if.byte_count !== checksums_due[0].byte_count) begin
            $error("byte_count: expected %0d, actual %0d",
                   checksums_due[0].byte_count, res_if.byte_count);
            fail_count++;
          end
          void'(checksums_due.pop_front());
        end
      end
      res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on handshake activity
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results still due",
                 STALL_LIMIT, checksums_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // queue one word; noise and bytes count toward the target differently
  task automatic queue_word(logic [7:0] d, logic hb, logic lst, bit drain = 0);
    msg_word_t w;
    w.data_byte  = d;
    w.has_byte   = hb;
    w.last       = lst;
    w.wait_drain = drain;
    pending_words.push_back(w);
    if (hb || lst) queued_words++;
  endtask

  // one whole message of random bytes, with optional noise words mixed in
  task automatic queue_message(int len, bit close_with_byte, bit drain);
    int body;
    body = close_with_byte ? len - 1 : len;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(99) < 8)
        queue_word(8'($urandom), 1'b0, 1'b0, drain && i == 0);
      queue_word(8'($urandom), 1'b1, 1'b0, drain && i == 0);
    end
    if (close_with_byte)
      queue_word(8'($urandom), 1'b1, 1'b1, drain && body == 0);
    else
      queue_word(8'($urandom), 1'b0, 1'b1, drain && body == 0);
  endtask

  initial begin
    int  len;
    int  roll;
    int  long_msgs;
    bit  with_byte;

    long_msgs = 0;
    msg_if.valid     = 1'b0;
    msg_if.data_byte = 8'h00;
    msg_if.has_byte  = 1'b0;
    msg_if.last      = 1'b0;
    res_if.ready     = 1'b0;

    // directed: idle word, empty messages, byte extremes, ignored data
    queue_word(8'h00, 1'b0, 1'b0);          // no byte, no close: no effect
    queue_word(8'h00, 1'b0, 1'b1);          // empty message right after reset
    queue_word(8'hFF, 1'b0, 1'b1);          // empty, data on the bus ignored
    queue_word(8'hFF, 1'b1, 1'b1);          // single byte, all ones
    queue_word(8'h00, 1'b1, 1'b1);          // single byte, all zeros
    queue_word(8'hA5, 1'b1, 1'b0);
    queue_word(8'h5A, 1'b0, 1'b0);          // ignored between bytes
    queue_word(8'h3C, 1'b1, 1'b1);
    queue_word(8'h80, 1'b1, 1'b0);
    queue_word(8'h01, 1'b1, 1'b0);
    queue_word(8'h7F, 1'b1, 1'b0);
    queue_word(8'hFE, 1'b0, 1'b1);          // close without a byte
    queue_word(8'h00, 1'b0, 1'b1, 1'b1);    // empty, sent once all is drained
    queue_word(8'h55, 1'b1, 1'b1);
    queue_word(8'hAA, 1'b1, 1'b1);
    queue_word(8'hC3, 1'b1, 1'b0, 1'b1);
    queue_word(8'h0F, 1'b1, 1'b1);

    // length 256: the low length byte folded in is zero
    queue_message(256, 1'b0, 1'b0);
    queue_message(255, 1'b1, 1'b1);

    // random messages, mostly short
    while (queued_words < WORD_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 10)
        len = 0;
      else if (roll < 85)
        len = $urandom_range(24, 1);
      else if (roll < 97 || long_msgs >= 2)
        len = $urandom_range(120, 25);
      else begin
        len = $urandom_range(300, 240);
        long_msgs++;
      end
      with_byte = (len > 0) && ($urandom_range(1) == 1);
      queue_message(len, with_byte, $urandom_range(99) < 5);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || msg_if.valid) @(posedge clk);
    while (checksums_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d messages (%0d empty, longest %0d bytes),",
             accepted_words, msgs_closed, empty_msgs, longest_msg);
    $display("checked %0d results with random stalls on both channels.",
             results_seen);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
